@@ rtl/core/alm_pkg.sv @@
// Shared types, constants and tables of the audio level meter.
// Used by every module under rtl/core and by the port checker.
`timescale 1ns / 1ps

package alm_pkg;

    localparam int LEVEL_W          = 17;
    localparam int COUNT_W          = 12;
    localparam int AGE_W            = 20;
    localparam int CFG_W            = 16;
    localparam int CFG_INDEX_W      = 8;
    localparam int DOTS_W           = 4;
    localparam int DOT_COUNT        = 13;
    // Smoothing ROM depth; a power of two from 16 to 256.
    localparam int SMOOTH_ROM_DEPTH = 64;
    localparam int SMOOTH_IDX_W     = $clog2(SMOOTH_ROM_DEPTH);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(65536);
    localparam logic [AGE_W-1:0]   AGE_MAX    = '1;

    localparam logic [CFG_W-1:0] DECAY_RATE_RESET    = CFG_W'(66);
    localparam logic [CFG_W-1:0] HOLD_DURATION_RESET = CFG_W'(2000);

    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_RATE    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_DURATION = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        KIND_LEVEL  = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_REDRAW = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // One event after the input register; count already turned into a factor.
    typedef struct packed {
        kind_t              kind;
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] smooth;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms_level;
        logic [LEVEL_W-1:0] decayed_peak;
        logic [LEVEL_W-1:0] hold_level;
        logic [DOTS_W-1:0]  lit_dots;
    } result_t;

    // round(0.9^k * 65536)
    function automatic logic [LEVEL_W-1:0] pow_whole(input logic [3:0] k);
        logic [LEVEL_W-1:0] v;
        case (k)
            4'd0:    v = LEVEL_W'(65536);
            4'd1:    v = LEVEL_W'(58982);
            4'd2:    v = LEVEL_W'(53084);
            4'd3:    v = LEVEL_W'(47776);
            4'd4:    v = LEVEL_W'(42998);
            4'd5:    v = LEVEL_W'(38698);
            4'd6:    v = LEVEL_W'(34829);
            4'd7:    v = LEVEL_W'(31346);
            4'd8:    v = LEVEL_W'(28211);
            4'd9:    v = LEVEL_W'(25390);
            4'd10:   v = LEVEL_W'(22851);
            4'd11:   v = LEVEL_W'(20566);
            4'd12:   v = LEVEL_W'(18509);
            4'd13:   v = LEVEL_W'(16658);
            4'd14:   v = LEVEL_W'(14993);
            default: v = LEVEL_W'(13493);
        endcase
        return v;
    endfunction

    // round(0.9^(k/16) * 65536)
    function automatic logic [LEVEL_W-1:0] pow_frac(input logic [3:0] k);
        logic [LEVEL_W-1:0] v;
        case (k)
            4'd0:    v = LEVEL_W'(65536);
            4'd1:    v = LEVEL_W'(65106);
            4'd2:    v = LEVEL_W'(64679);
            4'd3:    v = LEVEL_W'(64254);
            4'd4:    v = LEVEL_W'(63832);
            4'd5:    v = LEVEL_W'(63413);
            4'd6:    v = LEVEL_W'(62997);
            4'd7:    v = LEVEL_W'(62584);
            4'd8:    v = LEVEL_W'(62173);
            4'd9:    v = LEVEL_W'(61765);
            4'd10:   v = LEVEL_W'(61359);
            4'd11:   v = LEVEL_W'(60957);
            4'd12:   v = LEVEL_W'(60557);
            4'd13:   v = LEVEL_W'(60159);
            4'd14:   v = LEVEL_W'(59764);
            default: v = LEVEL_W'(59372);
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/alm_in_stage.sv @@
// Input register of the level meter: saturates levels and looks up the smoothing factor.
// Depends on alm_pkg.
`timescale 1ns / 1ps

module alm_in_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [alm_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    output logic                            item_valid,
    output alm_pkg::item_t                  item,
    input  logic                            item_take
);

    logic                             valid_reg;
    alm_pkg::item_t                   item_reg;
    alm_pkg::item_t                   item_next;
    logic [alm_pkg::LEVEL_W-1:0]      rms_raw;
    logic [alm_pkg::LEVEL_W-1:0]      peak_raw;
    logic [alm_pkg::COUNT_W-1:0]      count;
    logic [alm_pkg::SMOOTH_IDX_W-1:0] rom_idx;
    logic [7:0]                       expo;
    logic [2*alm_pkg::LEVEL_W-1:0]    smooth_prod;

    assign rms_raw  = s_tdata[alm_pkg::LEVEL_W-1:0];
    assign peak_raw = s_tdata[2*alm_pkg::LEVEL_W-1:alm_pkg::LEVEL_W];
    assign count    = s_tdata[2*alm_pkg::LEVEL_W+alm_pkg::COUNT_W-1:2*alm_pkg::LEVEL_W];

    // Exponent in sixteenths of a power of 0.9, one ROM row per group of samples.
    assign rom_idx = count[alm_pkg::COUNT_W-1:alm_pkg::COUNT_W-alm_pkg::SMOOTH_IDX_W];
    assign expo    = 8'({rom_idx, {(8 - alm_pkg::SMOOTH_IDX_W){1'b0}}});

    assign smooth_prod = alm_pkg::pow_whole(expo[7:4]) * alm_pkg::pow_frac(expo[3:0]);

    always_comb
    begin
        item_next.kind   = alm_pkg::kind_t'(s_tuser);
        item_next.rms    = (rms_raw > alm_pkg::FULL_SCALE) ? alm_pkg::FULL_SCALE : rms_raw;
        item_next.peak   = (peak_raw > alm_pkg::FULL_SCALE) ? alm_pkg::FULL_SCALE : peak_raw;
        item_next.smooth = alm_pkg::LEVEL_W'((smooth_prod + (2*alm_pkg::LEVEL_W)'(32768)) >> 16);
    end

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/alm_core.sv @@
// Meter state, configuration registers and the per-event update.
// Depends on alm_pkg; one shared multiplier serves smoothing and decay.
`timescale 1ns / 1ps

module alm_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [alm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [alm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              item_valid,
    input  alm_pkg::item_t                    item,
    input  logic                              result_space,
    output logic                              item_take,
    output alm_pkg::result_t                  result
);

    localparam int PROD_W     = 39;
    localparam int DOT_PROD_W = alm_pkg::LEVEL_W + $clog2(alm_pkg::DOT_COUNT + 1) + 1;

    logic [alm_pkg::CFG_W-1:0]   decay_rate_reg;
    logic [alm_pkg::CFG_W-1:0]   hold_dur_reg;
    logic [alm_pkg::LEVEL_W-1:0] rms_reg;
    logic [alm_pkg::LEVEL_W-1:0] rms_next;
    logic [alm_pkg::LEVEL_W-1:0] peak_reg;
    logic [alm_pkg::LEVEL_W-1:0] peak_next;
    logic [alm_pkg::LEVEL_W-1:0] decayed_reg;
    logic [alm_pkg::LEVEL_W-1:0] decayed_next;
    logic [alm_pkg::LEVEL_W-1:0] hold_reg;
    logic [alm_pkg::LEVEL_W-1:0] hold_next;
    logic [alm_pkg::AGE_W-1:0]   peak_age_reg;
    logic [alm_pkg::AGE_W-1:0]   peak_age_next;
    logic [alm_pkg::AGE_W-1:0]   hold_age_reg;
    logic [alm_pkg::AGE_W-1:0]   hold_age_next;

    logic signed [alm_pkg::LEVEL_W:0] rms_diff;
    logic signed [20:0]               mul_a;
    logic signed [17:0]               mul_b;
    logic signed [PROD_W-1:0]         mul_p;
    logic signed [PROD_W-1:0]         level_acc;
    logic [PROD_W-17:0]               rms_rnd;
    logic [DOT_PROD_W-1:0]            dot_sum;

    assign item_take = item_valid && result_space;

    // A level report blends as new*65536 + (old - new)*s, which equals
    // old*s + new*(65536 - s) with a single product.
    assign rms_diff = $signed({1'b0, rms_reg}) - $signed({1'b0, item.rms});

    always_comb
    begin
        if (item.kind == alm_pkg::KIND_LEVEL)
        begin
            mul_a = {{(21 - alm_pkg::LEVEL_W - 1){rms_diff[alm_pkg::LEVEL_W]}}, rms_diff};
            mul_b = $signed({1'b0, item.smooth});
        end
        else
        begin
            mul_a = $signed({1'b0, peak_age_reg});
            mul_b = $signed({2'b00, decay_rate_reg});
        end
    end

    assign mul_p     = mul_a * mul_b;
    assign level_acc = $signed({6'b0, item.rms, 16'b0}) + mul_p + PROD_W'(32768);
    assign rms_rnd   = level_acc[PROD_W-1:16];

    always_comb
    begin
        rms_next      = rms_reg;
        peak_next     = peak_reg;
        decayed_next  = decayed_reg;
        hold_next     = hold_reg;
        peak_age_next = peak_age_reg;
        hold_age_next = hold_age_reg;
        case (item.kind)
            alm_pkg::KIND_LEVEL:
            begin
                rms_next = (rms_rnd > (PROD_W - 16)'(alm_pkg::FULL_SCALE))
                         ? alm_pkg::FULL_SCALE : alm_pkg::LEVEL_W'(rms_rnd);
                if (item.peak > decayed_reg)
                begin
                    peak_next     = item.peak;
                    decayed_next  = item.peak;
                    peak_age_next = '0;
                end
                if (item.peak > hold_reg)
                begin
                    hold_next     = item.peak;
                    hold_age_next = '0;
                end
            end
            alm_pkg::KIND_TICK:
            begin
                if (peak_age_reg != alm_pkg::AGE_MAX)
                begin
                    peak_age_next = peak_age_reg + 1'b1;
                end
                if (hold_age_reg != alm_pkg::AGE_MAX)
                begin
                    hold_age_next = hold_age_reg + 1'b1;
                end
            end
            alm_pkg::KIND_REDRAW:
            begin
                // The product is never negative here: both operands are zero-extended.
                if (mul_p < $signed({{(PROD_W - alm_pkg::LEVEL_W){1'b0}}, peak_reg}))
                begin
                    decayed_next = peak_reg - mul_p[alm_pkg::LEVEL_W-1:0];
                end
                else
                begin
                    decayed_next = '0;
                end
                if (hold_age_reg > {{(alm_pkg::AGE_W - alm_pkg::CFG_W){1'b0}}, hold_dur_reg})
                begin
                    hold_next = '0;
                end
            end
            default:
            begin
                rms_next  = '0;
                peak_next = '0;
            end
        endcase
    end

    assign dot_sum = DOT_PROD_W'(decayed_next) * DOT_PROD_W'(alm_pkg::DOT_COUNT)
                   + DOT_PROD_W'(65535);

    always_comb
    begin
        result.rms_level    = rms_next;
        result.decayed_peak = decayed_next;
        result.hold_level   = hold_next;
        result.lit_dots     = dot_sum[16 +: alm_pkg::DOTS_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg <= alm_pkg::DECAY_RATE_RESET;
            hold_dur_reg   <= alm_pkg::HOLD_DURATION_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == alm_pkg::REG_DECAY_RATE)
            begin
                decay_rate_reg <= cfg_data;
            end
            else if (cfg_index == alm_pkg::REG_HOLD_DURATION)
            begin
                hold_dur_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rms_reg      <= '0;
            peak_reg     <= '0;
            decayed_reg  <= '0;
            hold_reg     <= '0;
            peak_age_reg <= '0;
            hold_age_reg <= '0;
        end
        else if (item_take)
        begin
            rms_reg      <= rms_next;
            peak_reg     <= peak_next;
            decayed_reg  <= decayed_next;
            hold_reg     <= hold_next;
            peak_age_reg <= peak_age_next;
            hold_age_reg <= hold_age_next;
        end
    end

endmodule

@@ rtl/core/alm_out_stage.sv @@
// Result register of the level meter and packing of the output beat.
// Depends on alm_pkg.
`timescale 1ns / 1ps

module alm_out_stage
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             result_load,
    input  alm_pkg::result_t                 result,
    output logic                             result_space,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [alm_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int PACK_W = $bits(alm_pkg::result_t);

    logic             valid_reg;
    alm_pkg::result_t result_reg;

    assign result_space = !valid_reg || m_tready;
    assign m_tvalid     = valid_reg;
    assign m_tdata      = {{(alm_pkg::OUT_DATA_W - PACK_W){1'b0}},
                           result_reg.lit_dots,
                           result_reg.hold_level,
                           result_reg.decayed_peak,
                           result_reg.rms_level};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ rtl/core/audio_level_meter_peak_hold.sv @@
// Top level of the audio level meter with peak decay and peak hold.
// Depends on alm_pkg, alm_in_stage, alm_core and alm_out_stage.
//
//   channel   direction  beat contents
//   s_*       in         tuser: kind; tdata: rms_in, peak_in, sample_count
//   m_*       out        tdata: rms_level, decayed_peak, hold_level, lit_dots
//   cfg_*     in         cfg_index selects the register, cfg_data is the value
//
// Every event gives one result beat on m_*, passing the input register and then the result register.
// A new event is taken in every cycle unless m_* stalls; the input register, the update logic
// with its shared multiplier and the result register form the path.
// A stall on m_* holds the result register and, once the input register is
// also full, s_tready drops. Reset clears all levels and ages and loads the
// default decay rate and hold time. Configuration writes are taken at once.
`timescale 1ns / 1ps

module audio_level_meter_peak_hold
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata bits from 0: rms_in[16:0], peak_in[33:17], sample_count[45:34], zeros
    input  logic [alm_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser: kind
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata bits from 0: rms_level[16:0], decayed_peak[33:17], hold_level[50:34],
    // lit_dots[54:51], zeros
    output logic [alm_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [alm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [alm_pkg::CFG_W-1:0]         cfg_data
);

    logic             item_valid;
    alm_pkg::item_t   item;
    logic             item_take;
    logic             result_space;
    alm_pkg::result_t result;

    assign cfg_ready = 1'b1;

    alm_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    alm_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item         (item),
        .result_space (result_space),
        .item_take    (item_take),
        .result       (result)
    );

    alm_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_load  (item_take),
        .result       (result),
        .result_space (result_space),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

@@ rtl/core/alm_checker.sv @@
// Port checker for the audio level meter, bound to the top level.
// Depends on alm_pkg and audio_level_meter_peak_hold.
`timescale 1ns / 1ps

module alm_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [alm_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic [alm_pkg::LEVEL_W-1:0] rms_level;
    logic [alm_pkg::LEVEL_W-1:0] decayed_peak;
    logic [alm_pkg::LEVEL_W-1:0] hold_level;
    logic [alm_pkg::DOTS_W-1:0]  lit_dots;

    assign rms_level    = m_tdata[16:0];
    assign decayed_peak = m_tdata[33:17];
    assign hold_level   = m_tdata[50:34];
    assign lit_dots     = m_tdata[54:51];

    // A held beat stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Levels never pass full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> rms_level <= alm_pkg::FULL_SCALE
                  && decayed_peak <= alm_pkg::FULL_SCALE
                  && hold_level <= alm_pkg::FULL_SCALE)
        else $error("level above full scale");

    // The dot count follows the decayed peak: none lit exactly when it is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (decayed_peak == '0) == (lit_dots == '0))
        else $error("dot count disagrees with decayed peak");

    // With the output stalled and the pipeline full, no further beat is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && !s_tready |=> !s_tready || m_tready)
        else $error("input taken while both stages are full");

endmodule

bind audio_level_meter_peak_hold alm_checker u_alm_checker (.*);
